/* rtl/core/tmi_pkg.sv */
// tape machine interpreter package: sizes, symbol and status codes,
// sequencer states and the control struct for the shared step unit
// no dependencies
package tmi_pkg;

    localparam int TAPE_DEPTH    = 4096;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int CELL_BITS     = 32;

    localparam int SYM_W    = 8;
    localparam int STATUS_W = 3;
    localparam int STOP_W   = 2;

    // program address, program length / counter, tape address, data pointer
    localparam int PA_W = $clog2(PROGRAM_DEPTH);
    localparam int PL_W = $clog2(PROGRAM_DEPTH + 1);
    localparam int TA_W = $clog2(TAPE_DEPTH);
    localparam int DP_W = TA_W + 1;

    // operand width of the shared step unit
    localparam int U_W = (CELL_BITS > DP_W) ?
                         ((CELL_BITS > PL_W) ? CELL_BITS : PL_W) :
                         ((DP_W > PL_W) ? DP_W : PL_W);

    localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h3E;
    localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h3C;
    localparam logic [SYM_W-1:0] SYM_INC   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_DEC   = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_OUT   = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_IN    = 8'h2C;
    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h5B;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h5D;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_END     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PTR     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BRACKET = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

    localparam logic [STOP_W-1:0] STOP_RUN     = 2'd0;
    localparam logic [STOP_W-1:0] STOP_END     = 2'd1;
    localparam logic [STOP_W-1:0] STOP_PTR     = 2'd2;
    localparam logic [STOP_W-1:0] STOP_BRACKET = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ADV,
        S_SREAD,
        S_SCHK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [U_W-1:0] operand;
        logic           dec;
    } step_ctl_t;

endpackage

/* rtl/core/tmi_in_if.sv */
// command channel of the tape machine interpreter: handshake plus op and symbol
// depends on tmi_pkg
interface tmi_in_if import tmi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink (input valid, input op, input symbol, output ready);
endinterface

/* rtl/core/tmi_out_if.sv */
// result channel of the tape machine interpreter: handshake plus result fields
// depends on tmi_pkg
interface tmi_out_if import tmi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                out_valid;
    logic [7:0]          out_byte;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_valid, output out_byte, output status,
                    input ready);
    modport sink (input valid, input out_valid, input out_byte, input status,
                  output ready);
endinterface

/* rtl/core/tape_machine_interpreter.sv */
// eight-command tape machine interpreter, top level
// uses tmi_pkg, tmi_in_if, tmi_out_if and tmi_step_unit
//
// usage:
//   cmd channel carries op and symbol. op load appends symbol to the program
//   store (status 4 when full); op step executes the instruction at the
//   program counter. every item gives exactly one item on the res channel
//   with out_valid, out_byte and status.
// sequence:
//   a load or a step that halts at once goes straight to the result state. a
//   plain step runs program and tape read, execute, program counter advance
//   through the shared step unit, result. a taken bracket jump adds, per
//   program symbol scanned, a program store read, then a nesting and index
//   update. one item is worked on at a time.
// reset:
//   rst_n clears all control state, then the tape is swept to zero one cell
//   a cycle, all TAPE_DEPTH (4096) cells, with cmd.ready low meanwhile.
// stalls:
//   the result sits in an output register; a new item is taken while it
//   waits, and the sequencer only holds at the end of that next item.
module tape_machine_interpreter import tmi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tmi_in_if.sink    cmd,
    tmi_out_if.source res
);

    state_t state_reg, state_next;

    logic [TA_W-1:0]   clr_reg, clr_next;
    logic [PL_W-1:0]   len_reg, len_next;
    logic [PL_W-1:0]   pc_reg, pc_next;
    logic [DP_W-1:0]   dp_reg, dp_next;
    logic [STOP_W-1:0] stop_reg, stop_next;
    logic [PL_W-1:0]   nest_reg, nest_next;
    logic [PL_W-1:0]   scan_idx_reg, scan_idx_next;
    logic              scan_fwd_reg, scan_fwd_next;

    logic                res_valid_reg, res_valid_next;
    logic [7:0]          res_byte_reg, res_byte_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                ovalid_reg, ovalid_next;
    logic                oout_valid_reg, oout_valid_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic [STATUS_W-1:0] ostatus_reg, ostatus_next;

    // memories
    logic [SYM_W-1:0]     prog_mem [PROGRAM_DEPTH];
    logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];
    logic [SYM_W-1:0]     prog_q;
    logic [CELL_BITS-1:0] tape_q;
    logic                 prog_we;
    logic [PA_W-1:0]      prog_raddr;
    logic                 tape_we;
    logic [TA_W-1:0]      tape_waddr;
    logic [CELL_BITS-1:0] tape_wdata;

    step_ctl_t      unit_ctl;
    logic [U_W-1:0] unit_res;

    logic accept;
    logic out_free;
    logic halt_now;
    logic cell_zero;
    logic is_open;
    logic is_close;
    logic found;
    logic scan_end;

    tmi_step_unit u_step (
        .ctl    (unit_ctl),
        .result (unit_res)
    );

    assign cmd.ready     = (state_reg == S_IDLE);
    assign accept        = cmd.valid && cmd.ready;
    assign out_free      = !ovalid_reg || res.ready;
    assign res.valid     = ovalid_reg;
    assign res.out_valid = oout_valid_reg;
    assign res.out_byte  = obyte_reg;
    assign res.status    = ostatus_reg;

    assign halt_now  = (stop_reg != STOP_RUN) || (pc_reg >= len_reg) ||
                       (dp_reg >= DP_W'(TAPE_DEPTH));
    assign cell_zero = (tape_q == '0);

    // bracket roles depend on scan direction
    assign is_open  = scan_fwd_reg ? (prog_q == SYM_OPEN) : (prog_q == SYM_CLOSE);
    assign is_close = scan_fwd_reg ? (prog_q == SYM_CLOSE) : (prog_q == SYM_OPEN);
    assign found    = is_close && (nest_reg == PL_W'(1));
    assign scan_end = scan_fwd_reg ? (unit_res[PL_W-1:0] == len_reg)
                                   : (scan_idx_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == TA_W'(TAPE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_LOAD || halt_now)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if ((prog_q == SYM_OPEN && cell_zero) ||
                    (prog_q == SYM_CLOSE && !cell_zero))
                begin
                    state_next = S_SREAD;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                state_next = S_RESP;
            end
            S_SREAD:
            begin
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (found)
                begin
                    state_next = S_ADV;
                end
                else if (scan_end)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SREAD;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next        = clr_reg;
        len_next        = len_reg;
        pc_next         = pc_reg;
        dp_next         = dp_reg;
        stop_next       = stop_reg;
        nest_next       = nest_reg;
        scan_idx_next   = scan_idx_reg;
        scan_fwd_next   = scan_fwd_reg;
        res_valid_next  = res_valid_reg;
        res_byte_next   = res_byte_reg;
        res_status_next = res_status_reg;
        ovalid_next     = ovalid_reg;
        oout_valid_next = oout_valid_reg;
        obyte_next      = obyte_reg;
        ostatus_next    = ostatus_reg;
        prog_we         = 1'b0;
        prog_raddr      = pc_reg[PA_W-1:0];
        tape_we         = 1'b0;
        tape_waddr      = dp_reg[TA_W-1:0];
        tape_wdata      = '0;
        unit_ctl.operand = '0;
        unit_ctl.dec     = 1'b0;

        if (res.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                clr_next   = clr_reg + TA_W'(1);
            end
            S_IDLE:
            begin
                unit_ctl.operand = U_W'(len_reg);
                if (accept)
                begin
                    res_valid_next  = 1'b0;
                    res_byte_next   = '0;
                    res_status_next = STATUS_OK;
                    if (cmd.op == OP_LOAD)
                    begin
                        if (len_reg < PL_W'(PROGRAM_DEPTH))
                        begin
                            prog_we  = 1'b1;
                            len_next = unit_res[PL_W-1:0];
                        end
                        else
                        begin
                            res_status_next = STATUS_FULL;
                        end
                    end
                    else if (stop_reg != STOP_RUN)
                    begin
                        res_status_next = STATUS_W'(stop_reg);
                    end
                    else if (pc_reg >= len_reg)
                    begin
                        stop_next       = STOP_END;
                        res_status_next = STATUS_END;
                    end
                    else if (dp_reg >= DP_W'(TAPE_DEPTH))
                    begin
                        stop_next       = STOP_PTR;
                        res_status_next = STATUS_PTR;
                    end
                end
            end
            S_EXEC:
            begin
                case (prog_q)
                    SYM_RIGHT:
                    begin
                        unit_ctl.operand = U_W'(dp_reg);
                        dp_next          = unit_res[DP_W-1:0];
                    end
                    SYM_LEFT:
                    begin
                        unit_ctl.operand = U_W'(dp_reg);
                        unit_ctl.dec     = 1'b1;
                        dp_next          = unit_res[DP_W-1:0];
                    end
                    SYM_INC:
                    begin
                        unit_ctl.operand = U_W'(tape_q);
                        tape_we          = 1'b1;
                        tape_wdata       = unit_res[CELL_BITS-1:0];
                    end
                    SYM_DEC:
                    begin
                        unit_ctl.operand = U_W'(tape_q);
                        unit_ctl.dec     = 1'b1;
                        tape_we          = 1'b1;
                        tape_wdata       = unit_res[CELL_BITS-1:0];
                    end
                    SYM_OUT:
                    begin
                        res_valid_next = 1'b1;
                        res_byte_next  = tape_q[7:0];
                    end
                    SYM_IN:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = '0;
                    end
                    SYM_OPEN, SYM_CLOSE:
                    begin
                        scan_idx_next = pc_reg;
                        nest_next     = '0;
                        scan_fwd_next = (prog_q == SYM_OPEN);
                    end
                    default:
                    begin
                        dp_next = dp_reg;
                    end
                endcase
            end
            S_ADV:
            begin
                unit_ctl.operand = U_W'(pc_reg);
                pc_next          = unit_res[PL_W-1:0];
            end
            S_SREAD:
            begin
                prog_raddr = scan_idx_reg[PA_W-1:0];
            end
            S_SCHK:
            begin
                unit_ctl.operand = U_W'(scan_idx_reg);
                unit_ctl.dec     = !scan_fwd_reg;
                if (is_open)
                begin
                    nest_next = nest_reg + PL_W'(1);
                end
                else if (is_close)
                begin
                    nest_next = nest_reg - PL_W'(1);
                end
                if (found)
                begin
                    pc_next = scan_idx_reg;
                end
                else if (scan_end)
                begin
                    // unmatched bracket, program counter stays put
                    stop_next       = STOP_BRACKET;
                    res_status_next = STATUS_BRACKET;
                end
                else
                begin
                    scan_idx_next = unit_res[PL_W-1:0];
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ovalid_next     = 1'b1;
                    oout_valid_next = res_valid_reg;
                    obyte_next      = res_byte_reg;
                    ostatus_next    = res_status_reg;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            len_reg      <= '0;
            pc_reg       <= '0;
            dp_reg       <= '0;
            stop_reg     <= STOP_RUN;
            nest_reg     <= '0;
            scan_idx_reg <= '0;
            scan_fwd_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            len_reg      <= len_next;
            pc_reg       <= pc_next;
            dp_reg       <= dp_next;
            stop_reg     <= stop_next;
            nest_reg     <= nest_next;
            scan_idx_reg <= scan_idx_next;
            scan_fwd_reg <= scan_fwd_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_valid_reg  <= res_valid_next;
        res_byte_reg   <= res_byte_next;
        res_status_reg <= res_status_next;
        oout_valid_reg <= oout_valid_next;
        obyte_reg      <= obyte_next;
        ostatus_reg    <= ostatus_next;
    end

    // program store, appended at the current length
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[len_reg[PA_W-1:0]] <= cmd.symbol;
        end
        prog_q <= prog_mem[prog_raddr];
    end

    // tape, read at the data pointer every cycle
    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_q <= tape_mem[dp_reg[TA_W-1:0]];
    end

endmodule

/* rtl/core/tmi_step_unit.sv */
// shared increment / decrement unit of the interpreter
// serves cells, data pointer, program counter, length and scan index; uses tmi_pkg
module tmi_step_unit import tmi_pkg::*;
(
    input  step_ctl_t      ctl,
    output logic [U_W-1:0] result
);

    assign result = ctl.operand + (ctl.dec ? {U_W{1'b1}} : U_W'(1));

endmodule
